/* rtl/nsc_pkg.sv */
package nsc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned INDEX_W   = 7;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned DIGIT_W   = 5;
	localparam int unsigned MAX_LEN_DEFAULT = 128;

	localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h24;
	localparam logic [BYTE_W-1:0] CHECK_CHAR_RST = 8'h2A;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_CHAR = 4'd0,
		REG_CHECK_CHAR = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_char;
		logic [BYTE_W-1:0] check_char;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  payload_byte;
		logic               payload_valid;
		logic [INDEX_W-1:0] payload_index;
		logic               sentence_done;
		logic               checksum_ok;
		logic               overflow;
	} res_t;

endpackage

/* rtl/nsc_if.sv */
interface nsc_stream_if #(
	parameter type payload_t = logic [nsc_pkg::BYTE_W-1:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface nsc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [nsc_pkg::CFG_IDX_W-1:0]  index;
	logic [nsc_pkg::BYTE_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/nmea_sentence_checksum_receiver_unit.sv */
// A result is offered after its byte passes the input register, then the
// output register; it is delayed further only while res is stalled.
// Throughput: one byte per cycle unless res stalls; a skid stage holds one
// result through an output stall before rx ready drops. Reset (arst_n low,
// asynchronous) returns to hunting for the start character, empties both
// stages and restores the defaults of start_char ('$') and check_char ('*').
module nmea_sentence_checksum_receiver_unit #(
	parameter int unsigned MAX_LEN = nsc_pkg::MAX_LEN_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	nsc_cfg_if.sink      cfg,
	nsc_stream_if.sink   rx,
	nsc_stream_if.source res
);

	nsc_pkg::cfg_t cfg_q;

	nsc_stream_if #(.payload_t(nsc_pkg::res_t)) par_ch ();

	nsc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	nsc_parser #(.MAX_LEN(MAX_LEN)) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_q  (cfg_q),
		.rx     (rx),
		.res    (par_ch)
	);

	nsc_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (par_ch),
		.dn     (res)
	);

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.checksum_ok |->
			res.data.sentence_done && !res.data.overflow)
		else $error("checksum_ok without a clean sentence end");

	a_done_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.sentence_done |-> !res.data.payload_valid)
		else $error("sentence end carries a payload byte");

	a_payload_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.payload_valid |-> !res.data.overflow)
		else $error("payload byte emitted after overflow");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		par_ch.valid && !par_ch.ready |=> par_ch.valid)
		else $error("stalled parser result lost");

endmodule

/* rtl/nsc_cfg_regs.sv */
module nsc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	nsc_cfg_if.sink       cfg,
	output nsc_pkg::cfg_t cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_char <= nsc_pkg::START_CHAR_RST;
			cfg_q.check_char <= nsc_pkg::CHECK_CHAR_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				nsc_pkg::REG_START_CHAR: cfg_q.start_char <= cfg.data;
				nsc_pkg::REG_CHECK_CHAR: cfg_q.check_char <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/nsc_parser.sv */
module nsc_parser #(
	parameter int unsigned MAX_LEN = nsc_pkg::MAX_LEN_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  nsc_pkg::cfg_t cfg_q,
	nsc_stream_if.sink    rx,
	nsc_stream_if.source  res
);

	localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_DATA,
		PH_HIGH,
		PH_LOW
	} phase_t;

	// bit 4 flags a byte that is not a hex digit
	function automatic logic [nsc_pkg::DIGIT_W-1:0] hex_value(
		input logic [nsc_pkg::BYTE_W-1:0] c
	);
		logic [nsc_pkg::BYTE_W-1:0] v;
		begin
			v = 8'h10;
			if (c inside {[8'h30:8'h39]}) begin
				v = c - 8'h30;
			end else if (c inside {[8'h41:8'h46]}) begin
				v = c - 8'h37;
			end else if (c inside {[8'h61:8'h66]}) begin
				v = c - 8'h57;
			end
			return v[nsc_pkg::DIGIT_W-1:0];
		end
	endfunction

	logic                         valid_s1;
	logic [nsc_pkg::BYTE_W-1:0]   byte_s1;
	phase_t                       phase_q;
	logic [nsc_pkg::BYTE_W-1:0]   xor_q;
	logic [nsc_pkg::DIGIT_W-1:0]  high_q;
	logic [CNT_W-1:0]             count_q;
	logic                         ovf_q;

	logic                         adv;
	logic                         is_start;
	logic                         is_check;
	logic                         room;
	logic [nsc_pkg::DIGIT_W-1:0]  digit;
	nsc_pkg::res_t                res_d;

	assign adv      = valid_s1 && res.ready;
	assign rx.ready = !valid_s1 || res.ready;
	assign is_start = (byte_s1 == cfg_q.start_char);
	assign is_check = (byte_s1 == cfg_q.check_char);
	assign room     = (count_q < CNT_MAX);
	assign digit    = hex_value(byte_s1);

	always_comb begin
		res_d = '0;
		case (phase_q)
			PH_HUNT: ;
			PH_DATA: begin
				if (!is_check && room) begin
					res_d.payload_byte  = byte_s1;
					res_d.payload_valid = 1'b1;
					res_d.payload_index = nsc_pkg::INDEX_W'(count_q);
				end
				res_d.overflow = ovf_q || (!is_check && !room);
			end
			PH_HIGH: res_d.overflow = ovf_q;
			PH_LOW: begin
				res_d.sentence_done = 1'b1;
				res_d.checksum_ok   = !high_q[4] && !digit[4] && !ovf_q &&
					({high_q[3:0], digit[3:0]} == xor_q);
				res_d.overflow      = ovf_q;
			end
			default: ;
		endcase
	end

	assign res.valid = valid_s1;
	assign res.data  = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			phase_q  <= PH_HUNT;
			xor_q    <= '0;
			high_q   <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
				byte_s1  <= rx.data;
			end
			if (adv) begin
				case (phase_q)
					PH_HUNT: begin
						if (is_start) begin
							phase_q <= PH_DATA;
							xor_q   <= '0;
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
					PH_DATA: begin
						if (is_check) begin
							phase_q <= PH_HIGH;
						end else if (room) begin
							count_q <= count_q + 1'b1;
							xor_q   <= xor_q ^ byte_s1;
						end else begin
							// drop the byte, keep the count at the limit
							ovf_q <= 1'b1;
						end
					end
					PH_HIGH: begin
						high_q  <= digit;
						phase_q <= PH_LOW;
					end
					PH_LOW:  phase_q <= PH_HUNT;
					default: phase_q <= PH_HUNT;
				endcase
			end
		end
	end

endmodule

/* rtl/nsc_out_buf.sv */
module nsc_out_buf (
	input  logic         clk,
	input  logic         arst_n,
	nsc_stream_if.sink   up,
	nsc_stream_if.source dn
);

	logic          main_v_q;
	logic          skid_v_q;
	nsc_pkg::res_t main_q;
	nsc_pkg::res_t skid_q;
	logic          push;
	logic          pop;

	assign up.ready = !skid_v_q;
	assign push     = up.valid && up.ready;
	assign pop      = main_v_q && dn.ready;
	assign dn.valid = main_v_q;
	assign dn.data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || pop) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			// hold the transaction aside while the output stalls
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			main_q <= skid_v_q ? skid_q : up.data;
		end else if (push) begin
			skid_q <= up.data;
		end
	end

endmodule

/* sim/nsc_sentence_checker.sv */
`timescale 1ns / 100ps

module nsc_sentence_checker #(
	parameter int unsigned MAX_LEN = nsc_pkg::MAX_LEN_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [nsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nsc_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          rx_valid,
	input  logic                          rx_ready,
	input  logic [nsc_pkg::BYTE_W-1:0]    rx_data,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  nsc_pkg::res_t                 res_data,
	output int unsigned                   outstanding,
	output int unsigned                   mismatches
);

	typedef enum logic [1:0] {
		SEEK,
		BODY,
		HI_NIB,
		LO_NIB
	} frame_state_t;

	frame_state_t                 state;
	logic [nsc_pkg::BYTE_W-1:0]   start_char;
	logic [nsc_pkg::BYTE_W-1:0]   check_char;
	logic [nsc_pkg::BYTE_W-1:0]   xor_acc;
	logic [nsc_pkg::DIGIT_W-1:0]  hi_nib;
	int unsigned                  body_len;
	logic                         ovf_seen;
	int unsigned                  errs;
	nsc_pkg::res_t                expected_q[$];

	// Bit 4 flags a byte that is not a hex digit.
	function automatic logic [nsc_pkg::DIGIT_W-1:0] hex_nibble(
		input logic [nsc_pkg::BYTE_W-1:0] c
	);
		logic [nsc_pkg::BYTE_W-1:0] d;
		d = '0;
		if (c >= "0" && c <= "9") begin
			d = c - "0";
		end else if (c >= "A" && c <= "F") begin
			d = c - "A" + 8'd10;
		end else if (c >= "a" && c <= "f") begin
			d = c - "a" + 8'd10;
		end else begin
			return 5'h10;
		end
		return {1'b0, d[3:0]};
	endfunction

	function automatic nsc_pkg::res_t next_result(input logic [nsc_pkg::BYTE_W-1:0] b);
		nsc_pkg::res_t               r;
		logic [nsc_pkg::DIGIT_W-1:0] lo;
		r = '0;
		case (state)
			SEEK: begin
				if (b == start_char) begin
					state    = BODY;
					xor_acc  = '0;
					body_len = 0;
					ovf_seen = 1'b0;
				end
			end
			BODY: begin
				if (b == check_char) begin
					state = HI_NIB;
				end else if (body_len < MAX_LEN) begin
					r.payload_byte  = b;
					r.payload_valid = 1'b1;
					r.payload_index = body_len[nsc_pkg::INDEX_W-1:0];
					body_len++;
					xor_acc ^= b;
				end else begin
					// drop bytes past the length limit
					ovf_seen = 1'b1;
				end
				r.overflow = ovf_seen;
			end
			HI_NIB: begin
				hi_nib     = hex_nibble(b);
				state      = LO_NIB;
				r.overflow = ovf_seen;
			end
			default: begin
				lo = hex_nibble(b);
				r.sentence_done = 1'b1;
				r.checksum_ok   = !hi_nib[4] && !lo[4] && !ovf_seen &&
					({hi_nib[3:0], lo[3:0]} == xor_acc);
				r.overflow      = ovf_seen;
				state           = SEEK;
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string name, input int unsigned want_v,
		input int unsigned got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, name, want_v, got_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		nsc_pkg::res_t want;
		if (!arst_n) begin
			state       = SEEK;
			start_char  = nsc_pkg::START_CHAR_RST;
			check_char  = nsc_pkg::CHECK_CHAR_RST;
			xor_acc     = '0;
			hi_nib      = '0;
			body_len    = 0;
			ovf_seen    = 1'b0;
			errs        = 0;
			expected_q.delete();
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					nsc_pkg::REG_START_CHAR: start_char = cfg_data;
					nsc_pkg::REG_CHECK_CHAR: check_char = cfg_data;
					default: ;
				endcase
			end
			if (rx_valid && rx_ready)
				expected_q.push_back(next_result(rx_data));
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with none expected, expected nothing, actual %h",
						$time, res_data);
					errs++;
				end else begin
					want = expected_q.pop_front();
					compare_field("payload_byte", want.payload_byte,
						res_data.payload_byte);
					compare_field("payload_valid", want.payload_valid,
						res_data.payload_valid);
					compare_field("payload_index", want.payload_index,
						res_data.payload_index);
					compare_field("sentence_done", want.sentence_done,
						res_data.sentence_done);
					compare_field("checksum_ok", want.checksum_ok,
						res_data.checksum_ok);
					compare_field("overflow", want.overflow, res_data.overflow);
				end
			end
			outstanding <= expected_q.size();
			mismatches  <= errs;
		end
	end

endmodule

/* sim/nmea_sentence_checksum_receiver_unit_tb.sv */
`timescale 1ns / 100ps

module nmea_sentence_checksum_receiver_unit_tb;

	localparam int unsigned SENT_MAX    = nsc_pkg::MAX_LEN_DEFAULT;
	localparam int unsigned PHASE_BYTES = 120;
	localparam logic [nsc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = nsc_pkg::CFG_IDX_W'(9);

	// Non-hex bytes sitting just outside the digit ranges
	localparam logic [nsc_pkg::BYTE_W-1:0] HEX_EDGE [6] = '{
		8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67
	};

	localparam logic [nsc_pkg::BYTE_W-1:0] OPENING [27] = '{
		8'hFF,
		nsc_pkg::START_CHAR_RST, 8'h00, 8'hFF, nsc_pkg::START_CHAR_RST,
		nsc_pkg::CHECK_CHAR_RST, "D", "B",
		nsc_pkg::START_CHAR_RST, nsc_pkg::CHECK_CHAR_RST, "0", "0",
		nsc_pkg::START_CHAR_RST, "a", nsc_pkg::CHECK_CHAR_RST, "G", "1",
		nsc_pkg::START_CHAR_RST, "b", nsc_pkg::CHECK_CHAR_RST, "6", "z",
		nsc_pkg::START_CHAR_RST, "N", nsc_pkg::CHECK_CHAR_RST, "4", "f"
	};

	typedef enum int unsigned {
		SENT_GOOD,
		SENT_BAD_SUM,
		SENT_BAD_HEX,
		SENT_CUT
	} sent_kind_t;

	typedef enum logic [1:0] {
		SINK_FREE,
		SINK_COIN,
		SINK_SLUGGISH,
		SINK_PERIODIC
	} sink_mode_t;

	logic                       clk;
	logic                       arst_n;
	int unsigned                pending_results;
	int unsigned                fail_count;
	int unsigned                burst_left;
	int unsigned                body_bytes;
	logic [nsc_pkg::BYTE_W-1:0] cur_start;
	logic [nsc_pkg::BYTE_W-1:0] cur_check;
	sink_mode_t                 sink_mode;
	int unsigned                sink_left;

	nsc_cfg_if                                   cfg_ch();
	nsc_stream_if                                rx_ch();
	nsc_stream_if #(.payload_t(nsc_pkg::res_t))  res_ch();

	nmea_sentence_checksum_receiver_unit #(
		.MAX_LEN(SENT_MAX)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.rx    (rx_ch),
		.res   (res_ch)
	);

	nsc_sentence_checker #(
		.MAX_LEN(SENT_MAX)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_ch.valid),
		.cfg_ready  (cfg_ch.ready),
		.cfg_index  (cfg_ch.index),
		.cfg_data   (cfg_ch.data),
		.rx_valid   (rx_ch.valid),
		.rx_ready   (rx_ch.ready),
		.rx_data    (rx_ch.data),
		.res_valid  (res_ch.valid),
		.res_ready  (res_ch.ready),
		.res_data   (res_ch.data),
		.outstanding(pending_results),
		.mismatches (fail_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Result side: pick a new random stall pattern whenever the current run ends
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_mode    <= SINK_FREE;
			sink_left    <= 0;
		end else begin
			if (sink_left == 0) begin
				sink_mode <= sink_mode_t'($urandom_range(0, 3));
				sink_left <= $urandom_range(1, 60);
			end else begin
				sink_left <= sink_left - 1;
			end
			case (sink_mode)
				SINK_FREE:     res_ch.ready <= 1'b1;
				SINK_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
				SINK_SLUGGISH: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default:       res_ch.ready <= (sink_left[2:0] != 3'd0);
			endcase
		end
	end

	initial begin
		#2_000_000;
		$display("nmea_sentence_checksum_receiver_unit_tb: FAIL");
		$finish;
	end

	function automatic logic [nsc_pkg::BYTE_W-1:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return "0" + {4'h0, n};
		return ($urandom_range(0, 1) ? "A" : "a") + {4'h0, n} - 8'd10;
	endfunction

	// Hold valid across a burst; drop it for a random gap at the end of one
	task automatic send_byte(input logic [nsc_pkg::BYTE_W-1:0] b);
		rx_ch.valid <= 1'b1;
		rx_ch.data  <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		if (burst_left == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	task automatic await_quiet();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	task automatic set_framing(input logic [nsc_pkg::BYTE_W-1:0] s,
		input logic [nsc_pkg::BYTE_W-1:0] c, input bit poke_unmapped);
		logic [nsc_pkg::CFG_IDX_W-1:0] idx [3];
		logic [nsc_pkg::BYTE_W-1:0]    val [3];
		idx[0] = REG_UNMAPPED;
		val[0] = nsc_pkg::BYTE_W'($urandom);
		idx[1] = nsc_pkg::REG_START_CHAR;
		val[1] = s;
		idx[2] = nsc_pkg::REG_CHECK_CHAR;
		val[2] = c;
		for (int i = poke_unmapped ? 0 : 1; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= val[i];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		cur_start = s;
		cur_check = c;
	endtask

	task automatic send_sentence(input int unsigned len, input sent_kind_t kind);
		logic [nsc_pkg::BYTE_W-1:0] sum;
		logic [nsc_pkg::BYTE_W-1:0] b;
		logic [nsc_pkg::BYTE_W-1:0] hi;
		logic [nsc_pkg::BYTE_W-1:0] lo;
		int unsigned                spoil;
		sum = '0;
		send_byte(cur_start);
		for (int unsigned i = 0; i < len; i++) begin
			b = nsc_pkg::BYTE_W'($urandom);
			while (b == cur_check && kind != SENT_CUT)
				b = nsc_pkg::BYTE_W'($urandom);
			if (i < SENT_MAX)
				sum ^= b;
			send_byte(b);
		end
		body_bytes += len + 1;
		// a cut sentence runs on into whatever follows
		if (kind == SENT_CUT)
			return;
		send_byte(cur_check);
		if (kind == SENT_BAD_SUM)
			sum ^= nsc_pkg::BYTE_W'($urandom_range(1, 255));
		hi = hex_char(sum[7:4]);
		lo = hex_char(sum[3:0]);
		if (kind == SENT_BAD_HEX) begin
			spoil = $urandom_range(0, 2);
			if ($urandom_range(0, 1)) begin
				b = HEX_EDGE[$urandom_range(0, 5)];
			end else begin
				b = nsc_pkg::BYTE_W'($urandom);
				while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
					(b >= "a" && b <= "f"))
					b = nsc_pkg::BYTE_W'($urandom);
			end
			if (spoil != 1)
				hi = b;
			if (spoil != 0)
				lo = b;
		end
		send_byte(hi);
		send_byte(lo);
		body_bytes += 3;
	endtask

	initial begin
		int unsigned                budget;
		int unsigned                pick;
		int unsigned                len;
		sent_kind_t                 kind;
		logic [nsc_pkg::BYTE_W-1:0] s;
		logic [nsc_pkg::BYTE_W-1:0] c;
		arst_n       <= 1'b0;
		rx_ch.valid  <= 1'b0;
		rx_ch.data   <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= nsc_pkg::REG_START_CHAR;
		cfg_ch.data  <= '0;
		burst_left   = 0;
		body_bytes   = 0;
		cur_start    = nsc_pkg::START_CHAR_RST;
		cur_check    = nsc_pkg::CHECK_CHAR_RST;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			if (ph != 0)
				await_quiet();
			case (ph)
				1: set_framing(8'h00, 8'hFF, 1'b1);
				2: set_framing(8'hFF, 8'h00, 1'b0);
				3: begin
					s = nsc_pkg::BYTE_W'($urandom);
					set_framing(s, s, 1'b0);
				end
				4: begin
					s = nsc_pkg::BYTE_W'($urandom);
					c = nsc_pkg::BYTE_W'($urandom);
					while (c == s)
						c = nsc_pkg::BYTE_W'($urandom);
					set_framing(s, c, 1'b1);
				end
				5: set_framing(nsc_pkg::START_CHAR_RST, nsc_pkg::CHECK_CHAR_RST, 1'b0);
				default: begin
					foreach (OPENING[i])
						send_byte(OPENING[i]);
				end
			endcase
			// walk the length limit across the phases
			send_sentence(SENT_MAX - 1 + ph, SENT_GOOD);
			budget = body_bytes + PHASE_BYTES;
			while (body_bytes < budget) begin
				repeat ($urandom_range(0, 3))
					send_byte(nsc_pkg::BYTE_W'($urandom));
				pick = $urandom_range(0, 99);
				kind = (pick < 70) ? SENT_GOOD : (pick < 82) ? SENT_BAD_SUM :
					(pick < 94) ? SENT_BAD_HEX : SENT_CUT;
				pick = $urandom_range(0, 99);
				if (pick < 75)
					len = $urandom_range(0, 12);
				else if (pick < 97)
					len = $urandom_range(13, 60);
				else
					len = $urandom_range(SENT_MAX - 2, SENT_MAX + 8);
				send_sentence(len, kind);
				if ($urandom_range(0, 39) == 0)
					await_quiet();
			end
		end

		await_quiet();
		repeat (8)
			@(posedge clk);
		if (fail_count == 0)
			$display("nmea_sentence_checksum_receiver_unit_tb: PASS");
		else
			$display("nmea_sentence_checksum_receiver_unit_tb: FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/nsc_pkg.sv
rtl/nsc_if.sv
rtl/nsc_cfg_regs.sv
rtl/nsc_parser.sv
rtl/nsc_out_buf.sv
rtl/nmea_sentence_checksum_receiver_unit.sv
sim/nsc_sentence_checker.sv
sim/nmea_sentence_checksum_receiver_unit_tb.sv
